>>> sv/bgti_pkg.sv
// Shared types and constants for the bilinear grid table interpolator.
package bgti_pkg;

    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_X_ORIGIN       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_X_INV_STEP     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_N_X_CELLS      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_ORIGIN   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_INV_STEP = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_N_ALPHA_CELLS  = 3'd5;

    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    // Depths of the command and result queues.
    localparam int MID_DEPTH = 4;
    localparam int MID_CW    = $clog2(MID_DEPTH + 1);
    localparam int OUT_DEPTH = 8;
    localparam int OUT_CW    = $clog2(OUT_DEPTH + 1);

    // Widest fraction carried in the command queue.
    localparam int FRAC_MAX = 24;

    typedef struct packed {
        logic               action;
        logic signed [31:0] alpha_coord;
        logic signed [31:0] x_coord;
        logic [5:0]         entry_alpha_index;
        logic [5:0]         entry_x_index;
        logic signed [31:0] entry_first_value;
        logic signed [31:0] entry_second_value;
    } req_t;

    typedef struct packed {
        logic signed [31:0] first_result;
        logic signed [31:0] second_result;
        logic               in_range;
    } result_t;

    typedef struct packed {
        logic signed [31:0] x_origin;
        logic [31:0]        x_inv_step;
        logic [5:0]         n_x_cells;
        logic signed [31:0] alpha_origin;
        logic [31:0]        alpha_inv_step;
        logic [5:0]         n_alpha_cells;
    } cfg_t;

    // Classified request handed from the front part to the back part.
    typedef struct packed {
        logic                action;
        logic                in_range;
        logic [5:0]          ia;
        logic [5:0]          ix;
        logic [5:0]          ia1;
        logic [5:0]          ix1;
        logic [3:0]          corner_ok; // {a1x1, a1x0, a0x1, a0x0}
        logic [FRAC_MAX-1:0] fa;
        logic [FRAC_MAX-1:0] fx;
        logic [5:0]          wa;
        logic [5:0]          wx;
        logic                w_in_store;
        logic [31:0]         w_first;
        logic [31:0]         w_second;
    } cmd_t;

endpackage

>>> sv/bgti_fifo.sv
// Small register queue with occupancy count.
module bgti_fifo import bgti_pkg::*; #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         wr_en,
    input  logic [WIDTH-1:0]             wdata,
    input  logic                         rd_en,
    output logic [WIDTH-1:0]             rdata,
    output logic                         is_empty,
    output logic [$clog2(DEPTH+1)-1:0]   count
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PW-1:0]    wptr_reg, wptr_next, rptr_reg, rptr_next;
    logic [CW-1:0]    count_reg, count_next;

    always_comb
    begin
        wptr_next  = wptr_reg;
        rptr_next  = rptr_reg;
        count_next = count_reg;
        if (wr_en)
        begin
            wptr_next = (wptr_reg == PW'(DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
        end
        if (rd_en)
        begin
            rptr_next = (rptr_reg == PW'(DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
        end
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!wr_en && rd_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wptr_reg] <= wdata;
        end
    end

    assign rdata    = mem[rptr_reg];
    assign is_empty = (count_reg == '0);
    assign count    = count_reg;
endmodule

>>> sv/bgti_front.sv
// Front part: coordinate scaling and range classification of requests.
module bgti_front import bgti_pkg::*; #(
    parameter int MAX_X_POINTS     = 64,
    parameter int MAX_ALPHA_POINTS = 64,
    parameter int FRACTION_BITS    = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  cfg_t              cfg,
    input  logic              push,
    output logic              full,
    input  req_t              request,
    input  logic [MID_CW-1:0] mid_count,
    output logic              mid_push,
    output cmd_t              mid_cmd
);
    localparam int FB = FRACTION_BITS;

    logic        a_valid_reg, b_valid_reg;
    req_t        a_req_reg, b_req_reg;
    logic [32:0] a_da_reg, a_dx_reg, a_da_next, a_dx_next;
    logic [63:0] b_pa_reg, b_px_reg;
    logic        b_na_reg, b_nx_reg;
    logic [MID_CW:0] occ;
    logic        accept;

    logic [31:0]   ia_w, ix_w;
    logic [FB-1:0] fa_w, fx_w;
    logic          a_ok, x_ok;
    logic [5:0]    ia, ix, ia1, ix1;

    // Queue slots already promised to requests in flight.
    assign occ  = (MID_CW+1)'(mid_count) + (MID_CW+1)'(a_valid_reg)
                + (MID_CW+1)'(b_valid_reg);
    assign full = (occ >= (MID_CW+1)'(MID_DEPTH));
    assign accept = push && !full;

    assign a_da_next = {request.alpha_coord[31], request.alpha_coord}
                     - {cfg.alpha_origin[31], cfg.alpha_origin};
    assign a_dx_next = {request.x_coord[31], request.x_coord}
                     - {cfg.x_origin[31], cfg.x_origin};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= accept;
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        a_req_reg <= request;
        a_da_reg  <= a_da_next;
        a_dx_reg  <= a_dx_next;
        b_req_reg <= a_req_reg;
        b_na_reg  <= a_da_reg[32];
        b_nx_reg  <= a_dx_reg[32];
        b_pa_reg  <= {32'b0, a_da_reg[31:0]} * {32'b0, cfg.alpha_inv_step};
        b_px_reg  <= {32'b0, a_dx_reg[31:0]} * {32'b0, cfg.x_inv_step};
    end

    // Integer part is the cell index, top fraction bits the weight.
    assign ia_w = b_pa_reg[63:32];
    assign ix_w = b_px_reg[63:32];
    assign fa_w = b_pa_reg[31:32-FB];
    assign fx_w = b_px_reg[31:32-FB];

    assign a_ok = !b_na_reg && ((ia_w < {26'b0, cfg.n_alpha_cells})
                  || (ia_w == {26'b0, cfg.n_alpha_cells} && fa_w == '0));
    assign x_ok = !b_nx_reg && ((ix_w < {26'b0, cfg.n_x_cells})
                  || (ix_w == {26'b0, cfg.n_x_cells} && fx_w == '0));

    assign ia  = ia_w[5:0];
    assign ix  = ix_w[5:0];
    assign ia1 = (ia < cfg.n_alpha_cells) ? ia + 6'd1 : ia;
    assign ix1 = (ix < cfg.n_x_cells) ? ix + 6'd1 : ix;

    always_comb
    begin
        mid_cmd.action       = b_req_reg.action;
        mid_cmd.in_range     = a_ok && x_ok;
        mid_cmd.ia           = ia;
        mid_cmd.ix           = ix;
        mid_cmd.ia1          = ia1;
        mid_cmd.ix1          = ix1;
        mid_cmd.corner_ok[0] = (32'(ia) < 32'(MAX_ALPHA_POINTS))
                             && (32'(ix) < 32'(MAX_X_POINTS));
        mid_cmd.corner_ok[1] = (32'(ia) < 32'(MAX_ALPHA_POINTS))
                             && (32'(ix1) < 32'(MAX_X_POINTS));
        mid_cmd.corner_ok[2] = (32'(ia1) < 32'(MAX_ALPHA_POINTS))
                             && (32'(ix) < 32'(MAX_X_POINTS));
        mid_cmd.corner_ok[3] = (32'(ia1) < 32'(MAX_ALPHA_POINTS))
                             && (32'(ix1) < 32'(MAX_X_POINTS));
        mid_cmd.fa           = FRAC_MAX'(fa_w);
        mid_cmd.fx           = FRAC_MAX'(fx_w);
        mid_cmd.wa           = b_req_reg.entry_alpha_index;
        mid_cmd.wx           = b_req_reg.entry_x_index;
        mid_cmd.w_in_store   = (32'(b_req_reg.entry_alpha_index) < 32'(MAX_ALPHA_POINTS))
                             && (32'(b_req_reg.entry_x_index) < 32'(MAX_X_POINTS));
        mid_cmd.w_first      = b_req_reg.entry_first_value;
        mid_cmd.w_second     = b_req_reg.entry_second_value;
    end

    assign mid_push = b_valid_reg;
endmodule

>>> sv/bgti_back.sv
// Back part: banked grid store and two-axis interpolation pipeline.
module bgti_back import bgti_pkg::*; #(
    parameter int MAX_X_POINTS     = 64,
    parameter int MAX_ALPHA_POINTS = 64,
    parameter int SAMPLE_WIDTH     = 32,
    parameter int FRACTION_BITS    = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              mid_empty,
    input  cmd_t              mid_cmd,
    output logic              mid_pop,
    input  logic [OUT_CW-1:0] out_count,
    output logic              out_push,
    output result_t           out_item
);
    localparam int SW     = SAMPLE_WIDTH;
    localparam int FB     = FRACTION_BITS;
    localparam int BA     = (MAX_ALPHA_POINTS + 1) / 2;
    localparam int BX     = (MAX_X_POINTS + 1) / 2;
    localparam int BDEPTH = BA * BX;
    localparam int AW     = (BDEPTH > 1) ? $clog2(BDEPTH) : 1;
    localparam int PW     = SW + FB + 2;
    localparam logic signed [PW-1:0] HALF = PW'(1) <<< (FB - 1);

    function automatic logic [AW-1:0] bank_addr(input logic [5:0] a, input logic [5:0] x);
        int v;
        v = int'(a[5:1]) * BX + int'(x[5:1]);
        return v[AW-1:0];
    endfunction

    logic c_valid_reg, d_valid_reg, e_valid_reg, f_valid_reg;
    cmd_t c_cmd_reg, d_cmd_reg, e_cmd_reg, f_cmd_reg;
    logic [OUT_CW:0] occ;

    logic [2*SW-1:0] rd_reg [4];

    logic signed [SW:0]   d_blo_reg [2], d_bhi_reg [2];
    logic signed [PW-1:0] d_plo_reg [2], d_phi_reg [2];
    logic signed [SW:0]   e_lo_reg [2], e_hi_reg [2];
    logic signed [SW:0]   f_lo_reg [2];
    logic signed [PW-1:0] f_p_reg [2];

    logic [2*SW-1:0]      corner [4];
    logic signed [SW:0]   s [4][2];
    logic signed [FB:0]   fx_s, fa_s;
    logic signed [PW-1:0] t_lo [2], t_hi [2], t_f [2];
    logic signed [SW:0]   res [2];

    // Results already promised to output queue slots.
    assign occ = (OUT_CW+1)'(out_count) + (OUT_CW+1)'(c_valid_reg)
               + (OUT_CW+1)'(d_valid_reg) + (OUT_CW+1)'(e_valid_reg)
               + (OUT_CW+1)'(f_valid_reg);
    assign mid_pop = !mid_empty && (occ < (OUT_CW+1)'(OUT_DEPTH));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
            f_valid_reg <= 1'b0;
        end
        else
        begin
            c_valid_reg <= mid_pop;
            d_valid_reg <= c_valid_reg;
            e_valid_reg <= d_valid_reg;
            f_valid_reg <= e_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        c_cmd_reg <= mid_cmd;
        d_cmd_reg <= c_cmd_reg;
        e_cmd_reg <= d_cmd_reg;
        f_cmd_reg <= e_cmd_reg;
    end

    // Four banks split by index parity: a cell's corners share a bank only where they coincide.
    for (genvar b = 0; b < 4; b++)
    begin : g_bank
        logic [2*SW-1:0] mem [BDEPTH];
        logic [5:0]      ra, rx;
        logic            wr_en;

        assign ra = (mid_cmd.ia[0] == b[1]) ? mid_cmd.ia : mid_cmd.ia1;
        assign rx = (mid_cmd.ix[0] == b[0]) ? mid_cmd.ix : mid_cmd.ix1;
        assign wr_en = mid_pop && (mid_cmd.action == ACT_WRITE) && mid_cmd.w_in_store
                     && (mid_cmd.wa[0] == b[1]) && (mid_cmd.wx[0] == b[0]);

        always_ff @(posedge clk)
        begin
            if (wr_en)
            begin
                mem[bank_addr(mid_cmd.wa, mid_cmd.wx)] <=
                    {mid_cmd.w_second[SW-1:0], mid_cmd.w_first[SW-1:0]};
            end
            rd_reg[b] <= mem[bank_addr(ra, rx)];
        end
    end

    always_comb
    begin
        corner[0] = rd_reg[{c_cmd_reg.ia[0],  c_cmd_reg.ix[0]}];
        corner[1] = rd_reg[{c_cmd_reg.ia[0],  c_cmd_reg.ix1[0]}];
        corner[2] = rd_reg[{c_cmd_reg.ia1[0], c_cmd_reg.ix[0]}];
        corner[3] = rd_reg[{c_cmd_reg.ia1[0], c_cmd_reg.ix1[0]}];
        for (int c = 0; c < 4; c++)
        begin
            if (!c_cmd_reg.corner_ok[c])
            begin
                corner[c] = '0;
            end
            s[c][0] = {corner[c][SW-1], corner[c][SW-1:0]};
            s[c][1] = {corner[c][2*SW-1], corner[c][2*SW-1:SW]};
        end
        fx_s = $signed({1'b0, c_cmd_reg.fx[FB-1:0]});
        fa_s = $signed({1'b0, e_cmd_reg.fa[FB-1:0]});
    end

    // lerp(a, b, f) = a + floor(((b - a) * f + half) / 2^FB)
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 2; k++)
        begin
            d_blo_reg[k] <= s[0][k];
            d_bhi_reg[k] <= s[2][k];
            d_plo_reg[k] <= PW'((s[1][k] - s[0][k]) * fx_s);
            d_phi_reg[k] <= PW'((s[3][k] - s[2][k]) * fx_s);
            e_lo_reg[k]  <= d_blo_reg[k] + t_lo[k][SW:0];
            e_hi_reg[k]  <= d_bhi_reg[k] + t_hi[k][SW:0];
            f_lo_reg[k]  <= e_lo_reg[k];
            f_p_reg[k]   <= PW'((e_hi_reg[k] - e_lo_reg[k]) * fa_s);
        end
    end

    always_comb
    begin
        for (int k = 0; k < 2; k++)
        begin
            t_lo[k] = (d_plo_reg[k] + HALF) >>> FB;
            t_hi[k] = (d_phi_reg[k] + HALF) >>> FB;
            t_f[k]  = (f_p_reg[k] + HALF) >>> FB;
            res[k]  = f_lo_reg[k] + t_f[k][SW:0];
        end
        if (f_cmd_reg.in_range)
        begin
            out_item.first_result  = 32'($signed(res[0][SW-1:0]));
            out_item.second_result = 32'($signed(res[1][SW-1:0]));
            out_item.in_range      = 1'b1;
        end
        else
        begin
            out_item.first_result  = '0;
            out_item.second_result = '0;
            out_item.in_range      = 1'b0;
        end
    end

    assign out_push = f_valid_reg && (f_cmd_reg.action == ACT_QUERY);
endmodule

>>> sv/bilinear_grid_table_interpolator_core.sv
// Top level of the bilinear grid table interpolator.
// Usage:
//   Requests enter through a queue-style port: a request is taken at a clock
//   edge with push high and full low. action 0 stores one grid entry (both
//   samples) and gives no result; action 1 is a query and gives one result.
//   Results leave through a queue-style port: while empty is low the oldest
//   result sits on result, and pop high at an edge takes it.
//   Configuration registers are written over cfg_valid/cfg_ready (ready is
//   always high) with cfg_index selecting x_origin, x_inv_step, n_x_cells,
//   alpha_origin, alpha_inv_step, n_alpha_cells; write only while idle.
// Timing:
//   One request per cycle sustained while full stays low. A query result
//   reaches the result port through two front stages (subtract, scale
//   multiply), the command queue, four back stages (banked store read, x-axis
//   multiply, x-axis round, alpha-axis multiply) and the result queue.
//   The four store banks, split by index parity, give all cell corners in
//   one read.
// Reset clears control state and the configuration to its defaults; the
// grid store is undefined until written. When the receiver stops popping,
// the result queue fills, the back part stops taking commands, the command
// queue fills and full rises; nothing is dropped.
module bilinear_grid_table_interpolator_core import bgti_pkg::*; #(
    parameter int MAX_X_POINTS     = 64,
    parameter int MAX_ALPHA_POINTS = 64,
    parameter int SAMPLE_WIDTH     = 32,
    parameter int FRACTION_BITS    = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  req_t                 request,
    output logic                 empty,
    input  logic                 pop,
    output result_t              result,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data
);
    cfg_t cfg_reg, cfg_next;

    logic              mid_push, mid_pop, mid_empty;
    cmd_t              mid_wcmd, mid_rcmd;
    logic [MID_CW-1:0] mid_count;
    logic              out_push;
    result_t           out_item;
    logic [OUT_CW-1:0] out_count;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_X_ORIGIN:       cfg_next.x_origin       = cfg_data;
                CFG_X_INV_STEP:     cfg_next.x_inv_step     = cfg_data;
                CFG_N_X_CELLS:      cfg_next.n_x_cells      = cfg_data[5:0];
                CFG_ALPHA_ORIGIN:   cfg_next.alpha_origin   = cfg_data;
                CFG_ALPHA_INV_STEP: cfg_next.alpha_inv_step = cfg_data;
                CFG_N_ALPHA_CELLS:  cfg_next.n_alpha_cells  = cfg_data[5:0];
                default:            cfg_next = cfg_reg; // unused indexes ignored
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.x_origin       <= '0;
            cfg_reg.x_inv_step     <= 32'd65536;
            cfg_reg.n_x_cells      <= 6'd63;
            cfg_reg.alpha_origin   <= '0;
            cfg_reg.alpha_inv_step <= 32'd65536;
            cfg_reg.n_alpha_cells  <= 6'd63;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Front: scale and classify, credit-limited into the command queue.
    bgti_front #(
        .MAX_X_POINTS     (MAX_X_POINTS),
        .MAX_ALPHA_POINTS (MAX_ALPHA_POINTS),
        .FRACTION_BITS    (FRACTION_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .push      (push),
        .full      (full),
        .request   (request),
        .mid_count (mid_count),
        .mid_push  (mid_push),
        .mid_cmd   (mid_wcmd)
    );

    bgti_fifo #(
        .WIDTH ($bits(cmd_t)),
        .DEPTH (MID_DEPTH)
    ) u_mid_q (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (mid_push),
        .wdata    (mid_wcmd),
        .rd_en    (mid_pop),
        .rdata    (mid_rcmd),
        .is_empty (mid_empty),
        .count    (mid_count)
    );

    // Back: store access and interpolation, credit-limited into result queue.
    bgti_back #(
        .MAX_X_POINTS     (MAX_X_POINTS),
        .MAX_ALPHA_POINTS (MAX_ALPHA_POINTS),
        .SAMPLE_WIDTH     (SAMPLE_WIDTH),
        .FRACTION_BITS    (FRACTION_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .mid_empty (mid_empty),
        .mid_cmd   (mid_rcmd),
        .mid_pop   (mid_pop),
        .out_count (out_count),
        .out_push  (out_push),
        .out_item  (out_item)
    );

    bgti_fifo #(
        .WIDTH ($bits(result_t)),
        .DEPTH (OUT_DEPTH)
    ) u_out_q (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (out_push),
        .wdata    (out_item),
        .rd_en    (pop && !empty),
        .rdata    (result),
        .is_empty (empty),
        .count    (out_count)
    );
endmodule
